// ===== design/nfsa_pkg.sv =====
`default_nettype none

package nfsa_pkg;

	// Field widths of the request, the result and the registers
	localparam int unsigned SLOT_W  = 8;
	localparam int unsigned SIZE_W  = 9;
	localparam int unsigned ADDR_W  = 48;
	localparam int unsigned INC_W   = 9;
	localparam int unsigned PROD_W  = INC_W + SLOT_W;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 48;

	// Used map word: 32 slots per memory word, at most 8 words for 256 slots
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned BIT_W    = 5;
	localparam int unsigned WIDX_W   = SLOT_W - BIT_W;
	localparam int unsigned MAX_SLOTS = 256;

	// Request kinds
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INCREMENT_SIZE = 2'd3;

	// Register reset values
	localparam logic [SIZE_W-1:0] SLOTS_IN_USE_RST = 9'd256;
	localparam logic [INC_W-1:0]  INCREMENT_RST    = 9'd32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_SRD,
		ST_SCHK,
		ST_ADDR,
		ST_FRD,
		ST_FCHK,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== design/nfsa_req_if.sv =====
`default_nettype none

interface nfsa_req_if;
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic [nfsa_pkg::SLOT_W-1:0]    slot;

	modport source (output valid, output cmd, output slot, input ready);
	modport sink   (input valid, input cmd, input slot, output ready);
endinterface

`default_nettype wire

// ===== design/nfsa_res_if.sv =====
`default_nettype none

interface nfsa_res_if;
	logic                           valid;
	logic                           ready;
	logic                           granted;
	logic [nfsa_pkg::SLOT_W-1:0]    slot_index;
	logic [nfsa_pkg::ADDR_W-1:0]    cpu_address;
	logic [nfsa_pkg::ADDR_W-1:0]    gpu_address;
	logic [nfsa_pkg::SIZE_W-1:0]    used_count;

	modport source (output valid, output granted, output slot_index, output cpu_address,
		output gpu_address, output used_count, input ready);
	modport sink   (input valid, input granted, input slot_index, input cpu_address,
		input gpu_address, input used_count, output ready);
endinterface

`default_nettype wire

// ===== design/next_fit_slot_allocator_core.sv =====
// Allocate: reads and checks one 32-slot used-map word at a time from the pointer, then
//   forms the addresses and stages the result; a bitwise remainder step first reduces a
//   pointer at or beyond the active size; a zero active size stages a denial directly.
// Free: read, modify, stage; a slot at or beyond the active size is staged directly.
// One request in flight; the next is taken the cycle after its result is staged, and
//   staging waits for the output register. Reset frees every slot via per-word valid bits.
`default_nettype none

module next_fit_slot_allocator_core #(
	parameter int unsigned SLOTS = 256
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [nfsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [nfsa_pkg::CFG_DATA_W-1:0]     cfg_data,
	nfsa_req_if.sink                                 req,
	nfsa_res_if.source                               res
);

	localparam int unsigned MAP   = (SLOTS < nfsa_pkg::MAX_SLOTS) ? SLOTS : nfsa_pkg::MAX_SLOTS;
	localparam int unsigned WORDS = (MAP + nfsa_pkg::WORD_W - 1) / nfsa_pkg::WORD_W;
	localparam int unsigned WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

	// Configuration registers
	logic [nfsa_pkg::SIZE_W-1:0] slots_in_use_q;
	logic [nfsa_pkg::ADDR_W-1:0] cpu_base_q;
	logic [nfsa_pkg::ADDR_W-1:0] gpu_base_q;
	logic [nfsa_pkg::INC_W-1:0]  increment_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= nfsa_pkg::SLOTS_IN_USE_RST;
			cpu_base_q     <= '0;
			gpu_base_q     <= '0;
			increment_q    <= nfsa_pkg::INCREMENT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				nfsa_pkg::REG_SLOTS_IN_USE:   slots_in_use_q <= cfg_data[nfsa_pkg::SIZE_W-1:0];
				nfsa_pkg::REG_CPU_BASE:       cpu_base_q     <= cfg_data[nfsa_pkg::ADDR_W-1:0];
				nfsa_pkg::REG_GPU_BASE:       gpu_base_q     <= cfg_data[nfsa_pkg::ADDR_W-1:0];
				nfsa_pkg::REG_INCREMENT_SIZE: increment_q    <= cfg_data[nfsa_pkg::INC_W-1:0];
				default: ;
			endcase
		end
	end

	// Active pool size and derived search bounds
	logic [nfsa_pkg::SIZE_W-1:0] size;
	logic [nfsa_pkg::SIZE_W-1:0] size_m1;
	logic [nfsa_pkg::WIDX_W-1:0] last_word;
	logic [nfsa_pkg::BIT_W-1:0]  last_bit;

	assign size      = (slots_in_use_q > nfsa_pkg::SIZE_W'(MAP)) ? nfsa_pkg::SIZE_W'(MAP)
		: slots_in_use_q;
	assign size_m1   = size - 9'd1;
	assign last_word = size_m1[nfsa_pkg::SLOT_W-1:nfsa_pkg::BIT_W];
	assign last_bit  = size_m1[nfsa_pkg::BIT_W-1:0];

	// Control and working state
	nfsa_pkg::state_t state_q, state_nxt;
	logic [nfsa_pkg::SLOT_W-1:0] next_ptr_q;
	logic [nfsa_pkg::SIZE_W-1:0] used_total_q;
	logic [nfsa_pkg::SLOT_W-1:0] start_q;     // scan start, reduced below size
	logic [nfsa_pkg::SIZE_W-1:0] rem_q;       // remainder of the pointer reduction
	logic [2:0]                  bcnt_q;      // remainder bit counter
	logic [nfsa_pkg::WIDX_W-1:0] wcnt_q;      // word under scan
	logic                        pass_q;      // 0: start..end, 1: wrapped part
	logic [nfsa_pkg::SLOT_W-1:0] slot_q;
	logic [nfsa_pkg::SLOT_W-1:0] idx_q;
	logic [nfsa_pkg::PROD_W-1:0] prod_q;
	logic [WORDS-1:0]            word_vld_q;
	logic                        res_valid_q;

	// Staged result
	logic                        rs_granted_q;
	logic [nfsa_pkg::SLOT_W-1:0] rs_index_q;
	logic [nfsa_pkg::ADDR_W-1:0] rs_cpu_q;
	logic [nfsa_pkg::ADDR_W-1:0] rs_gpu_q;

	// Used-map memory: one word per 32 slots, registered read
	logic [nfsa_pkg::WORD_W-1:0] map_mem [WORDS];
	logic [nfsa_pkg::WORD_W-1:0] rd_word_q;
	logic                        rd_vld_q;
	logic [WA_W-1:0]             map_addr;
	logic                        map_we;
	logic [nfsa_pkg::WORD_W-1:0] map_wdata;
	logic [nfsa_pkg::WORD_W-1:0] cur_word;

	assign map_addr = WA_W'(wcnt_q);
	assign cur_word = rd_vld_q ? rd_word_q : '0;

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_addr] <= map_wdata;
		end
		rd_word_q <= map_mem[map_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			rd_vld_q <= word_vld_q[map_addr];
			if (map_we) begin
				word_vld_q[map_addr] <= 1'b1;
			end
		end
	end

	// Search window inside the current word
	logic [nfsa_pkg::WORD_W-1:0] ones;
	logic [nfsa_pkg::WORD_W-1:0] lo_mask;
	logic [nfsa_pkg::WORD_W-1:0] hi_mask;
	logic [nfsa_pkg::WORD_W-1:0] free_bits;
	logic [nfsa_pkg::WORD_W-1:0] first_bit;
	logic [nfsa_pkg::BIT_W-1:0]  first_pos;
	logic                        found;
	logic [nfsa_pkg::WIDX_W-1:0] start_word;
	logic [nfsa_pkg::BIT_W-1:0]  start_bit;
	logic [nfsa_pkg::SLOT_W-1:0] hit_idx;
	logic [nfsa_pkg::SIZE_W-1:0] hit_inc;

	assign ones       = '1;
	assign start_word = start_q[nfsa_pkg::SLOT_W-1:nfsa_pkg::BIT_W];
	assign start_bit  = start_q[nfsa_pkg::BIT_W-1:0];

	always_comb begin
		lo_mask = ones;
		hi_mask = ones;
		if (!pass_q) begin
			if (wcnt_q == start_word) lo_mask = ones << start_bit;
			if (wcnt_q == last_word)  hi_mask = ones >> (5'd31 - last_bit);
		end else begin
			if (wcnt_q == start_word) hi_mask = ~(ones << start_bit);
		end
	end

	assign free_bits = ~cur_word & lo_mask & hi_mask;
	assign first_bit = free_bits & (~free_bits + 32'd1);
	assign found     = |free_bits;

	always_comb begin
		first_pos = '0;
		for (int i = 0; i < nfsa_pkg::WORD_W; i++) begin
			if (first_bit[i]) first_pos = first_pos | nfsa_pkg::BIT_W'(i);
		end
	end

	assign hit_idx = {wcnt_q, first_pos};
	assign hit_inc = {1'b0, hit_idx} + 9'd1;

	// Restoring remainder step for the pointer reduction
	logic [nfsa_pkg::SIZE_W-1:0] rem_sh;
	logic [nfsa_pkg::SIZE_W-1:0] rem_nxt;

	assign rem_sh  = {rem_q[nfsa_pkg::SLOT_W-1:0], next_ptr_q[bcnt_q]};
	assign rem_nxt = (rem_sh >= size) ? rem_sh - size : rem_sh;

	// Free path: bit of the addressed slot
	logic slot_used;
	assign slot_used = cur_word[slot_q[nfsa_pkg::BIT_W-1:0]];

	// Next state and handshake
	logic req_xfer;
	logic stage_ok;

	assign req_xfer  = req.valid && req.ready;
	assign stage_ok  = !res_valid_q || res.ready;

	always_comb begin
		state_nxt = state_q;
		req.ready = 1'b0;
		map_we    = 1'b0;
		map_wdata = cur_word;
		case (state_q)
			nfsa_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.cmd == nfsa_pkg::CMD_FREE) begin
						state_nxt = ({1'b0, req.slot} < size) ? nfsa_pkg::ST_FRD
							: nfsa_pkg::ST_DONE;
					end else if (size == '0) begin
						state_nxt = nfsa_pkg::ST_DONE;
					end else if ({1'b0, next_ptr_q} >= size) begin
						state_nxt = nfsa_pkg::ST_MOD;
					end else begin
						state_nxt = nfsa_pkg::ST_SRD;
					end
				end
			end
			nfsa_pkg::ST_MOD: begin
				if (bcnt_q == 3'd0) state_nxt = nfsa_pkg::ST_SRD;
			end
			nfsa_pkg::ST_SRD: begin
				state_nxt = nfsa_pkg::ST_SCHK;
			end
			nfsa_pkg::ST_SCHK: begin
				if (found) begin
					map_we    = 1'b1;
					map_wdata = cur_word | first_bit;
					state_nxt = nfsa_pkg::ST_ADDR;
				end else if (pass_q && wcnt_q == start_word) begin
					state_nxt = nfsa_pkg::ST_DONE;
				end else begin
					state_nxt = nfsa_pkg::ST_SRD;
				end
			end
			nfsa_pkg::ST_ADDR: begin
				state_nxt = nfsa_pkg::ST_DONE;
			end
			nfsa_pkg::ST_FRD: begin
				state_nxt = nfsa_pkg::ST_FCHK;
			end
			nfsa_pkg::ST_FCHK: begin
				if (slot_used) begin
					map_we    = 1'b1;
					map_wdata = cur_word & ~(32'd1 << slot_q[nfsa_pkg::BIT_W-1:0]);
				end
				state_nxt = nfsa_pkg::ST_DONE;
			end
			nfsa_pkg::ST_DONE: begin
				if (stage_ok) state_nxt = nfsa_pkg::ST_IDLE;
			end
			default: state_nxt = nfsa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nfsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Pointer, count and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_ptr_q   <= '0;
			used_total_q <= '0;
			start_q      <= '0;
			rem_q        <= '0;
			bcnt_q       <= '0;
			wcnt_q       <= '0;
			pass_q       <= 1'b0;
		end else begin
			case (state_q)
				nfsa_pkg::ST_IDLE: begin
					pass_q <= 1'b0;
					rem_q  <= '0;
					bcnt_q <= 3'd7;
					if (req_xfer) begin
						if (req.cmd == nfsa_pkg::CMD_FREE) begin
							wcnt_q <= req.slot[nfsa_pkg::SLOT_W-1:nfsa_pkg::BIT_W];
						end else begin
							start_q <= next_ptr_q;
							wcnt_q  <= next_ptr_q[nfsa_pkg::SLOT_W-1:nfsa_pkg::BIT_W];
						end
					end
				end
				nfsa_pkg::ST_MOD: begin
					rem_q  <= rem_nxt;
					bcnt_q <= bcnt_q - 3'd1;
					if (bcnt_q == 3'd0) begin
						start_q <= rem_nxt[nfsa_pkg::SLOT_W-1:0];
						wcnt_q  <= rem_nxt[nfsa_pkg::SLOT_W-1:nfsa_pkg::BIT_W];
					end
				end
				nfsa_pkg::ST_SCHK: begin
					if (found) begin
						used_total_q <= used_total_q + 9'd1;
						next_ptr_q   <= (hit_inc == size) ? '0 : hit_inc[nfsa_pkg::SLOT_W-1:0];
					end else if (!pass_q && wcnt_q == last_word) begin
						pass_q <= 1'b1;
						wcnt_q <= '0;
					end else begin
						wcnt_q <= wcnt_q + 3'd1;
					end
				end
				nfsa_pkg::ST_FCHK: begin
					if (slot_used) used_total_q <= used_total_q - 9'd1;
				end
				default: ;
			endcase
		end
	end

	// Result datapath: index times stride, then base add
	always_ff @(posedge clk) begin
		case (state_q)
			nfsa_pkg::ST_IDLE: begin
				slot_q       <= req.slot;
				rs_granted_q <= 1'b0;
				rs_index_q   <= '0;
				rs_cpu_q     <= '0;
				rs_gpu_q     <= '0;
			end
			nfsa_pkg::ST_SCHK: begin
				idx_q  <= hit_idx;
				prod_q <= nfsa_pkg::PROD_W'(increment_q) * nfsa_pkg::PROD_W'(hit_idx);
			end
			nfsa_pkg::ST_ADDR: begin
				rs_granted_q <= 1'b1;
				rs_index_q   <= idx_q;
				rs_cpu_q     <= cpu_base_q + nfsa_pkg::ADDR_W'(prod_q);
				rs_gpu_q     <= gpu_base_q + nfsa_pkg::ADDR_W'(prod_q);
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == nfsa_pkg::ST_DONE && stage_ok) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == nfsa_pkg::ST_DONE && stage_ok) begin
			res.granted     <= rs_granted_q;
			res.slot_index  <= rs_index_q;
			res.cpu_address <= rs_cpu_q;
			res.gpu_address <= rs_gpu_q;
			res.used_count  <= used_total_q;
		end
	end

	assign res.valid = res_valid_q;

	// Checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_total_q <= nfsa_pkg::SIZE_W'(MAP))
		else $error("used count beyond pool capacity");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> !req.ready)
		else $error("request taken while another is in flight");

	a_denied_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.granted |-> res.slot_index == '0 && res.cpu_address == '0
			&& res.gpu_address == '0)
		else $error("result without grant carries a slot or address");

endmodule

`default_nettype wire

// ===== tb/next_fit_slot_allocator_core_test.sv =====
`timescale 1ns / 1ps

module next_fit_slot_allocator_core_test;

	localparam int unsigned POOL_SLOTS   = 256;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned LONG_HOLD    = 400;
	localparam logic [nfsa_pkg::ADDR_W-1:0] ADDR_ONES = '1;

	typedef struct packed {
		logic                        granted;
		logic [nfsa_pkg::SLOT_W-1:0] slot_index;
		logic [nfsa_pkg::ADDR_W-1:0] cpu_address;
		logic [nfsa_pkg::ADDR_W-1:0] gpu_address;
		logic [nfsa_pkg::SIZE_W-1:0] used_count;
	} grant_t;

	// Tracks the pool the way the block should and queues the result of each request
	class slot_pool_tracker;
		logic [nfsa_pkg::SIZE_W-1:0] slots;
		logic [nfsa_pkg::ADDR_W-1:0] cpu_base;
		logic [nfsa_pkg::ADDR_W-1:0] gpu_base;
		logic [nfsa_pkg::INC_W-1:0]  stride;
		logic [POOL_SLOTS-1:0]       used;
		logic [nfsa_pkg::SLOT_W-1:0] next_ptr;
		logic [nfsa_pkg::SIZE_W-1:0] used_total;
		grant_t pending_grants[$];
		int errors;

		function new();
			slots = nfsa_pkg::SLOTS_IN_USE_RST;
			cpu_base = '0;
			gpu_base = '0;
			stride = nfsa_pkg::INCREMENT_RST;
			used = '0;
			next_ptr = '0;
			used_total = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [nfsa_pkg::CFG_IDX_W-1:0] idx,
				logic [nfsa_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				nfsa_pkg::REG_SLOTS_IN_USE:   slots = d[nfsa_pkg::SIZE_W-1:0];
				nfsa_pkg::REG_CPU_BASE:       cpu_base = d[nfsa_pkg::ADDR_W-1:0];
				nfsa_pkg::REG_GPU_BASE:       gpu_base = d[nfsa_pkg::ADDR_W-1:0];
				nfsa_pkg::REG_INCREMENT_SIZE: stride = d[nfsa_pkg::INC_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned active_size();
			if (slots > POOL_SLOTS)
				return POOL_SLOTS;
			return slots;
		endfunction

		// Next-fit scan from the pointer, wrapping at the active size; a free clears a used slot inside it
		function void take_request(logic c, logic [nfsa_pkg::SLOT_W-1:0] s);
			grant_t r;
			int unsigned size;
			int unsigned idx;
			int unsigned i;
			bit found;
			logic [nfsa_pkg::ADDR_W-1:0] offset;
			r = '0;
			size = active_size();
			found = 0;
			if (c == nfsa_pkg::CMD_ALLOC) begin
				i = 0;
				while (i < size && !found) begin
					idx = (int'(next_ptr) + i) % size;
					if (!used[idx]) begin
						found = 1;
						used[idx] = 1'b1;
						used_total = used_total + 1'b1;
						offset = nfsa_pkg::ADDR_W'(stride) * nfsa_pkg::ADDR_W'(idx);
						r.granted = 1'b1;
						r.slot_index = nfsa_pkg::SLOT_W'(idx);
						r.cpu_address = cpu_base + offset;
						r.gpu_address = gpu_base + offset;
						next_ptr = nfsa_pkg::SLOT_W'((idx + 1) % size);
					end
					i++;
				end
			end else if (s < size && used[s]) begin
				used[s] = 1'b0;
				used_total = used_total - 1'b1;
			end
			r.used_count = used_total;
			pending_grants.push_back(r);
		endfunction

		// A used slot inside the active size, for well-formed frees
		function bit pick_used(output logic [nfsa_pkg::SLOT_W-1:0] s);
			logic [nfsa_pkg::SLOT_W-1:0] cand[$];
			for (int i = 0; i < active_size(); i++)
				if (used[i])
					cand.push_back(nfsa_pkg::SLOT_W'(i));
			if (cand.size() == 0)
				return 0;
			s = cand[$urandom_range(0, cand.size() - 1)];
			return 1;
		endfunction

		function void report(string field, logic [nfsa_pkg::ADDR_W-1:0] want,
				logic [nfsa_pkg::ADDR_W-1:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		endfunction

		function void check_grant(grant_t got);
			grant_t want;
			if (pending_grants.size() == 0) begin
				errors++;
				$display("%0t: result with nothing outstanding, expected none, actual slot %0d",
					$time, got.slot_index);
				return;
			end
			want = pending_grants.pop_front();
			if (got.granted !== want.granted)
				report("granted", nfsa_pkg::ADDR_W'(want.granted),
					nfsa_pkg::ADDR_W'(got.granted));
			if (got.slot_index !== want.slot_index)
				report("slot_index", nfsa_pkg::ADDR_W'(want.slot_index),
					nfsa_pkg::ADDR_W'(got.slot_index));
			if (got.cpu_address !== want.cpu_address)
				report("cpu_address", want.cpu_address, got.cpu_address);
			if (got.gpu_address !== want.gpu_address)
				report("gpu_address", want.gpu_address, got.gpu_address);
			if (got.used_count !== want.used_count)
				report("used_count", nfsa_pkg::ADDR_W'(want.used_count),
					nfsa_pkg::ADDR_W'(got.used_count));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [nfsa_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [nfsa_pkg::CFG_DATA_W-1:0] cfg_data;

	nfsa_req_if req_ch();
	nfsa_res_if res_ch();

	slot_pool_tracker pool;
	int req_calm;
	int res_calm;
	bit long_hold;

	next_fit_slot_allocator_core #(
		.SLOTS(POOL_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.res(res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Random idle gap before an item, with the odd calm stretch of none
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			calm = $urandom_range(10, 40);
		return $urandom_range(0, 10);
	endfunction

	// Result side ready pattern, with an occasional long hold-off
	initial begin : result_sink
		int gap;
		res_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		res_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			gap = 0;
			if (res_ch.valid && res_ch.ready)
				gap = draw_gap(res_calm);
			if (long_hold) begin
				gap = LONG_HOLD;
				long_hold = 0;
			end
			if (gap != 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Result check and watchdog on transfer activity
	initial begin : result_watch
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready)
				pool.check_grant({res_ch.granted, res_ch.slot_index, res_ch.cpu_address,
					res_ch.gpu_address, res_ch.used_count});
			if (arst_n && ((res_ch.valid && res_ch.ready) || (req_ch.valid && req_ch.ready)))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	task automatic send_req(logic c, logic [nfsa_pkg::SLOT_W-1:0] s);
		int gap;
		gap = draw_gap(req_calm);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.slot <= s;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pool.take_request(c, s);
	endtask

	// Stop offering and let every outstanding result drain
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pool.pending_grants.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [nfsa_pkg::CFG_IDX_W-1:0] idx,
			logic [nfsa_pkg::CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		pool.set_reg(idx, d);
		@(posedge clk);
	endtask

	task automatic program_pool(logic [nfsa_pkg::SIZE_W-1:0] size,
			logic [nfsa_pkg::ADDR_W-1:0] cb, logic [nfsa_pkg::ADDR_W-1:0] gb,
			logic [nfsa_pkg::INC_W-1:0] inc);
		settle();
		write_reg(nfsa_pkg::REG_SLOTS_IN_USE, nfsa_pkg::CFG_DATA_W'(size));
		write_reg(nfsa_pkg::REG_CPU_BASE, cb);
		write_reg(nfsa_pkg::REG_GPU_BASE, gb);
		write_reg(nfsa_pkg::REG_INCREMENT_SIZE, nfsa_pkg::CFG_DATA_W'(inc));
		cfg_we <= 1'b0;
	endtask

	function automatic logic [nfsa_pkg::ADDR_W-1:0] draw_base();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return ADDR_ONES;
			2: return nfsa_pkg::ADDR_W'({$urandom, $urandom});
			default: return {32'hFFFF_FFFF, 16'($urandom)};
		endcase
	endfunction

	function automatic logic [nfsa_pkg::INC_W-1:0] draw_stride();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 9'd1;
			2: return 9'd256;
			3: return '1;
			4: return nfsa_pkg::INCREMENT_RST;
			default: return nfsa_pkg::INC_W'($urandom_range(1, 511));
		endcase
	endfunction

	function automatic logic [nfsa_pkg::SIZE_W-1:0] draw_size();
		case ($urandom_range(0, 6))
			0: return 9'd1;
			1: return 9'd2;
			2: return 9'd256;
			3: return nfsa_pkg::SIZE_W'($urandom_range(3, 16));
			4: return nfsa_pkg::SIZE_W'($urandom_range(17, 255));
			5: return nfsa_pkg::SIZE_W'($urandom_range(257, 511));
			default: return nfsa_pkg::SIZE_W'($urandom_range(1, 64));
		endcase
	endfunction

	// Random requests: frees mostly hit a slot in use
	task automatic run_phase(int count, int alloc_pct);
		logic c;
		logic [nfsa_pkg::SLOT_W-1:0] s;
		bit found;
		for (int n = 0; n < count; n++) begin
			found = 0;
			s = nfsa_pkg::SLOT_W'($urandom);
			if ($urandom_range(0, 99) < alloc_pct) begin
				c = nfsa_pkg::CMD_ALLOC;
			end else begin
				c = nfsa_pkg::CMD_FREE;
				if ($urandom_range(0, 3) != 0)
					found = pool.pick_used(s);
				if (!found)
					s = nfsa_pkg::SLOT_W'($urandom);
			end
			send_req(c, s);
		end
	endtask

	initial begin : main
		pool = new();
		req_calm = 0;
		res_calm = 0;
		long_hold = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= nfsa_pkg::REG_SLOTS_IN_USE;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= nfsa_pkg::CMD_ALLOC;
		req_ch.slot <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: plain next-fit, double free, free of a never-used slot
		send_req(nfsa_pkg::CMD_ALLOC, 8'd0);
		send_req(nfsa_pkg::CMD_ALLOC, 8'd0);
		send_req(nfsa_pkg::CMD_ALLOC, 8'd0);
		send_req(nfsa_pkg::CMD_FREE, 8'd1);
		send_req(nfsa_pkg::CMD_FREE, 8'd1);
		send_req(nfsa_pkg::CMD_FREE, 8'd255);
		send_req(nfsa_pkg::CMD_ALLOC, 8'd255);

		// Shrink to 4: pointer past size, pool full, free out of range, address wrap
		program_pool(9'd4, ADDR_ONES, 48'hFFFF_FFFF_FF00, 9'd256);
		send_req(nfsa_pkg::CMD_ALLOC, 8'd0);
		send_req(nfsa_pkg::CMD_ALLOC, 8'd0);
		send_req(nfsa_pkg::CMD_FREE, 8'd200);
		send_req(nfsa_pkg::CMD_FREE, 8'd2);
		send_req(nfsa_pkg::CMD_ALLOC, 8'd0);

		// Empty pool
		program_pool(9'd0, 48'h0000_0000_1000, 48'h0, 9'd32);
		send_req(nfsa_pkg::CMD_ALLOC, 8'd0);
		send_req(nfsa_pkg::CMD_FREE, 8'd0);

		// Zero stride; marks beyond the shrunken size still count
		program_pool(9'd2, draw_base(), 48'h0, 9'd0);
		send_req(nfsa_pkg::CMD_FREE, 8'd0);
		send_req(nfsa_pkg::CMD_ALLOC, 8'd0);
		send_req(nfsa_pkg::CMD_FREE, 8'd3);

		// Size beyond the pool clips to 256; widest stride
		program_pool(9'd511, ADDR_ONES, 48'h1, 9'd511);
		send_req(nfsa_pkg::CMD_ALLOC, 8'd0);
		send_req(nfsa_pkg::CMD_FREE, 8'd255);
		send_req(nfsa_pkg::CMD_ALLOC, 8'd0);

		// Full pool driven to exhaustion
		program_pool(9'd256, draw_base(), draw_base(), draw_stride());
		run_phase(300, 90);

		// Long result hold-off while requests keep coming
		program_pool(draw_size(), draw_base(), draw_base(), draw_stride());
		long_hold = 1;
		run_phase(112, 60);

		for (int p = 0; p < 11; p++) begin
			program_pool(draw_size(), draw_base(), draw_base(), draw_stride());
			run_phase(112, $urandom_range(30, 80));
		end

		settle();
		if (pool.errors == 0 && pool.pending_grants.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
